// ----- src/pcbr_pkg.sv -----
// ----------------------------------------------------------------------------
// Pointwise convolution package
// Shared constants, codes and the control structs of the cell row.
// ----------------------------------------------------------------------------
package pcbr_pkg;

  localparam int unsigned MaxInChannels  = 64;
  localparam int unsigned MaxOutChannels = 64;
  localparam int unsigned DataWidth      = 16;
  localparam int unsigned FracBits       = 8;
  localparam int unsigned AccGuard       = 8;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_ACT    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_IN_CHANNELS  = 2'd0,
    CFG_OUT_CHANNELS = 2'd1,
    CFG_RELU_ENABLE  = 2'd2
  } cfg_e;

  typedef struct packed {
    logic       w_we;
    logic       b_we;
    logic [5:0] oc;
    logic [5:0] ic;
    logic       mac_en;
    logic       acc_en;
    logic       load;
    logic       shift;
    logic       relu;
    logic [6:0] n_out;
  } cell_ctrl_t;

  typedef struct packed {
    logic       vld;
    logic       last;
    logic [5:0] chan;
  } cell_out_t;

endpackage

// ----- src/pcbr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pcbr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/pcbr_cell.sv -----
// ----------------------------------------------------------------------------
// Output channel cell
// Holds the weights, bias and accumulator of one output channel and one
// stage of the result shift chain towards the output.
// ----------------------------------------------------------------------------
module pcbr_cell #(
  parameter int unsigned IDX             = 0,
  parameter int unsigned MAX_IN_CHANNELS = pcbr_pkg::MaxInChannels,
  parameter int unsigned DATA_WIDTH      = pcbr_pkg::DataWidth,
  parameter int unsigned FRAC_BITS       = pcbr_pkg::FracBits,
  localparam int unsigned AW = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pcbr_pkg::cell_ctrl_t      ctrl_i,
  input  logic [DATA_WIDTH-1:0]     wdata_i,
  input  logic [DATA_WIDTH-1:0]     act_i,
  input  logic [AW-1:0]             raddr_i,
  input  pcbr_pkg::cell_out_t       next_i,
  input  logic [DATA_WIDTH-1:0]     next_res_i,
  output pcbr_pkg::cell_out_t       out_o,
  output logic [DATA_WIDTH-1:0]     res_o
);

  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned ACC_W = PW + pcbr_pkg::AccGuard;
  localparam int unsigned BEXT = ACC_W + 1 - DATA_WIDTH - FRAC_BITS;

  logic                  sel;
  logic                  active;
  logic                  is_last;
  logic [DATA_WIDTH-1:0] weight;
  logic [DATA_WIDTH-1:0] bias_q;
  logic signed [PW-1:0]  prod;
  logic [PW-1:0]         prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [ACC_W-1:0]      acc_d;
  logic signed [ACC_W:0] sum_s;
  logic signed [ACC_W:0] shr_s;
  logic                  fits;
  logic [DATA_WIDTH-1:0] sat;
  logic [DATA_WIDTH-1:0] final_res;
  pcbr_pkg::cell_out_t   out_q;
  pcbr_pkg::cell_out_t   out_d;
  logic [DATA_WIDTH-1:0] res_q;
  logic [DATA_WIDTH-1:0] res_d;

  assign sel     = (32'(ctrl_i.oc) == IDX);
  assign active  = (IDX < 32'(ctrl_i.n_out));
  assign is_last = ((32'(ctrl_i.n_out) - 32'd1) == IDX);

  pcbr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_IN_CHANNELS)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.w_we && sel),
    .waddr_i (AW'(ctrl_i.ic)),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (weight)
  );

  assign prod = $signed(weight) * $signed(act_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.b_we && sel) begin
      bias_q <= wdata_i;
    end
    if (ctrl_i.mac_en) begin
      prod_q <= prod;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en && active) begin
      acc_d = acc_q + {{pcbr_pkg::AccGuard{prod_q[PW-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    sum_s = $signed({acc_q[ACC_W-1], acc_q})
          + $signed({{BEXT{bias_q[DATA_WIDTH-1]}}, bias_q, {FRAC_BITS{1'b0}}});
    shr_s = sum_s >>> FRAC_BITS;
    fits  = (shr_s[ACC_W:DATA_WIDTH-1] == '0) || (shr_s[ACC_W:DATA_WIDTH-1] == '1);
    if (fits) begin
      sat = shr_s[DATA_WIDTH-1:0];
    end else if (shr_s[ACC_W]) begin
      sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    final_res = (ctrl_i.relu && sat[DATA_WIDTH-1]) ? '0 : sat;
  end

  always_comb begin
    out_d = out_q;
    res_d = res_q;
    if (ctrl_i.load) begin
      out_d.vld  = active;
      out_d.last = is_last;
      out_d.chan = 6'(IDX);
      res_d      = final_res;
    end else if (ctrl_i.shift) begin
      out_d = next_i;
      res_d = next_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o = out_q;
  assign res_o = res_q;

endmodule

// ----- src/pointwise_conv_bias_relu_core.sv -----
// ----------------------------------------------------------------------------
// Pointwise convolution core with bias and ReLU
// Weight and bias items load a row of per-output-channel cells; activation
// items are multiplied in every cell and accumulated in every active cell at once.
// ----------------------------------------------------------------------------
// Within a pixel one item is accepted per cycle; the first result is valid once
// the pixel's last activation has passed end1_q, end2_q and end3_q and been
// loaded, then one per cycle while out_ready_i is high. Input is held off from
// that activation until the last result is taken.
// Reset clears accumulators and counters and selects one input and one output
// channel without ReLU; the weight and bias tables stay undefined.
module pointwise_conv_bias_relu_core #(
  parameter int unsigned MAX_IN_CHANNELS  = pcbr_pkg::MaxInChannels,
  parameter int unsigned MAX_OUT_CHANNELS = pcbr_pkg::MaxOutChannels,
  parameter int unsigned DATA_WIDTH       = pcbr_pkg::DataWidth,
  parameter int unsigned FRAC_BITS        = pcbr_pkg::FracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [6:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [5:0]            out_channel_i,
  input  logic [5:0]            in_channel_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  last_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [5:0]            channel_o,
  output logic [DATA_WIDTH-1:0] result_o,
  output logic                  last_o,
  output logic                  frame_end_o
);

  localparam int unsigned AW = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;

  logic [6:0]            in_ch_q;
  logic [6:0]            out_ch_q;
  logic                  relu_q;
  logic [6:0]            n_in;
  logic [6:0]            n_out;
  logic                  in_acc;
  logic                  is_w;
  logic                  is_b;
  logic                  is_act;
  logic [6:0]            cnt_q;
  logic [6:0]            cnt_inc;
  logic                  pix_end;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] val_q;
  logic                  s1_q;
  logic                  s2_q;
  logic                  end1_q;
  logic                  end2_q;
  logic                  end3_q;
  logic                  busy_q;
  logic                  frame_q;
  logic                  frame_out_q;
  logic                  shift;
  pcbr_pkg::cell_ctrl_t  ctrl;
  pcbr_pkg::cell_out_t   chain [MAX_OUT_CHANNELS+1];
  logic [DATA_WIDTH-1:0] chain_res [MAX_OUT_CHANNELS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= 7'd1;
      out_ch_q <= 7'd1;
      relu_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (pcbr_pkg::cfg_e'(cfg_index_i))
        pcbr_pkg::CFG_IN_CHANNELS:  in_ch_q  <= cfg_data_i;
        pcbr_pkg::CFG_OUT_CHANNELS: out_ch_q <= cfg_data_i;
        pcbr_pkg::CFG_RELU_ENABLE:  relu_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_in = in_ch_q;
    if (in_ch_q == 7'd0) begin
      n_in = 7'd1;
    end else if (32'(in_ch_q) > MAX_IN_CHANNELS) begin
      n_in = 7'(MAX_IN_CHANNELS);
    end
    n_out = out_ch_q;
    if (out_ch_q == 7'd0) begin
      n_out = 7'd1;
    end else if (32'(out_ch_q) > MAX_OUT_CHANNELS) begin
      n_out = 7'(MAX_OUT_CHANNELS);
    end
  end

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    is_w   = 1'b0;
    is_b   = 1'b0;
    is_act = 1'b0;
    case (pcbr_pkg::op_e'(operation_i))
      pcbr_pkg::OP_WEIGHT: is_w   = (32'(in_channel_i) < MAX_IN_CHANNELS);
      pcbr_pkg::OP_BIAS:   is_b   = 1'b1;
      pcbr_pkg::OP_ACT:    is_act = 1'b1;
      default: ;
    endcase
  end

  assign cnt_inc = cnt_q + 7'd1;
  assign pix_end = (cnt_inc >= n_in);
  assign raddr   = (32'(cnt_q) >= MAX_IN_CHANNELS) ? AW'(MAX_IN_CHANNELS - 1) : AW'(cnt_q);
  assign shift   = !chain[0].vld || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      frame_q     <= 1'b0;
      frame_out_q <= 1'b0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      end1_q      <= 1'b0;
      end2_q      <= 1'b0;
      end3_q      <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      s1_q   <= in_acc && is_act;
      s2_q   <= s1_q;
      end1_q <= in_acc && is_act && pix_end;
      end2_q <= end1_q;
      end3_q <= end2_q;
      if (in_acc && is_act) begin
        if (pix_end) begin
          cnt_q       <= '0;
          frame_q     <= 1'b0;
          frame_out_q <= frame_q || last_pixel_i;
          busy_q      <= 1'b1;
        end else begin
          cnt_q   <= cnt_inc;
          frame_q <= frame_q || last_pixel_i;
        end
      end else if (out_valid_o && out_ready_i && last_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_act) begin
      val_q <= value_i;
    end
  end

  always_comb begin
    ctrl.w_we   = in_acc && is_w;
    ctrl.b_we   = in_acc && is_b;
    ctrl.oc     = out_channel_i;
    ctrl.ic     = in_channel_i;
    ctrl.mac_en = s1_q;
    ctrl.acc_en = s2_q;
    ctrl.load   = end3_q;
    ctrl.shift  = shift;
    ctrl.relu   = relu_q;
    ctrl.n_out  = n_out;
  end

  assign chain[MAX_OUT_CHANNELS]     = '0;
  assign chain_res[MAX_OUT_CHANNELS] = '0;

  for (genvar k = 0; k < MAX_OUT_CHANNELS; k++) begin : g_cell
    pcbr_cell #(
      .IDX             (k),
      .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
      .DATA_WIDTH      (DATA_WIDTH),
      .FRAC_BITS       (FRAC_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wdata_i    (value_i),
      .act_i      (val_q),
      .raddr_i    (raddr),
      .next_i     (chain[k+1]),
      .next_res_i (chain_res[k+1]),
      .out_o      (chain[k]),
      .res_o      (chain_res[k])
    );
  end

  assign out_valid_o = chain[0].vld;
  assign channel_o   = chain[0].chan;
  assign last_o      = chain[0].last;
  assign result_o    = chain_res[0];
  assign frame_end_o = frame_out_q;

  a_load_into_empty_chain : assert property (
    @(posedge clk_i) disable iff (!rst_ni) end3_q |-> !out_valid_o
  ) else $error("Results loaded while the chain still holds results.");

  a_no_input_while_draining : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !out_valid_o
  ) else $error("Input accepted while results are pending.");

  a_release_after_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o
  ) else $error("Input not released after the last result of a pixel.");

  a_end_holds_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni) end1_q || end2_q || end3_q |-> busy_q
  ) else $error("Pixel end in flight without input held off.");

endmodule
